[src/cses_pkg.sv]
// Shared types and constants for the CAN signal extract and scale block.
`default_nettype none
package cses_pkg;

  localparam int unsigned MAX_PAYLOAD_BYTES = 8;
  localparam int unsigned QUEUE_DEPTH       = 2;
  localparam int unsigned QUEUE_PTR_W       = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    MODE_UNSIGNED = 2'd0,
    MODE_SIGNED   = 2'd1,
    MODE_STRING   = 2'd2,
    MODE_DISABLED = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_START_POSITION = 3'd0,
    REG_BIT_COUNT      = 3'd1,
    REG_BIG_ENDIAN     = 3'd2,
    REG_VALUE_MODE     = 3'd3,
    REG_SCALE_FACTOR   = 3'd4,
    REG_SCALE_OFFSET   = 3'd5,
    REG_CLAMP_LOW      = 3'd6,
    REG_CLAMP_HIGH     = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [63:0] payload;
    logic [3:0]  payload_bytes;
  } frame_t;

  typedef struct packed {
    logic               ok;
    logic signed [63:0] raw_value;
    logic signed [63:0] scaled_value;
  } result_t;

  typedef struct packed {
    logic [5:0] start_position;
    logic [6:0] bit_count;
    logic       big_endian;
    mode_t      value_mode;
  } extract_cfg_t;

  typedef struct packed {
    logic signed [31:0] scale_factor;
    logic signed [47:0] scale_offset;
    logic signed [47:0] clamp_low;
    logic signed [47:0] clamp_high;
  } scale_cfg_t;

  typedef struct packed {
    logic               ok;
    logic               scale_en;
    logic signed [63:0] raw;
  } entry_t;

endpackage
`default_nettype wire

[src/can_signal_extract_scale_top.sv]
// Top level of the CAN signal extract and scale block.
`default_nettype none
// Decodes one configured signal (Intel or Motorola layout, optional sign
// extension) from each CAN frame payload and scales it as raw * factor (Q16.16)
// + offset (Q32.16) into a saturated, optionally clamped Q48.16 value. One frame
// is accepted per cycle while the queue is not full, and each gives exactly one
// result. A frame is decoded as it is accepted and queued; the scaling pipeline
// then registers a split 64x32 multiply, a wide sum with saturation and the clamp
// into the output register, and it stalls while a held result is not taken.
// The user must make configuration writes only while no frame is in flight; the block itself does not enforce it.
module can_signal_extract_scale_top (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              frame_valid,
  output logic                   frame_stall,
  input  wire cses_pkg::frame_t  frame,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output cses_pkg::result_t      result,
  input  wire logic              wr_en,
  input  wire logic [2:0]        wr_index,
  input  wire logic [47:0]       wr_data
);
  import cses_pkg::*;

  logic [5:0]         start_position;
  logic [6:0]         bit_count;
  logic               big_endian;
  mode_t              value_mode;
  logic signed [31:0] scale_factor;
  logic signed [47:0] scale_offset;
  logic signed [47:0] clamp_low;
  logic signed [47:0] clamp_high;

  extract_cfg_t ext_cfg;
  scale_cfg_t   scl_cfg;
  logic         push;
  entry_t       wr_entry;
  entry_t       rd_entry;
  logic         pop;
  logic         not_empty;
  logic         full;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_position <= 6'd0;
      bit_count      <= 7'd8;
      big_endian     <= 1'b0;
      value_mode     <= MODE_UNSIGNED;
      scale_factor   <= 32'sd65536;
      scale_offset   <= 48'sd0;
      clamp_low      <= 48'sd0;
      clamp_high     <= 48'sd0;
    end else if (wr_en) begin
      case (reg_index_t'(wr_index))
        REG_START_POSITION: start_position <= wr_data[5:0];
        REG_BIT_COUNT:      bit_count      <= wr_data[6:0];
        REG_BIG_ENDIAN:     big_endian     <= wr_data[0];
        REG_VALUE_MODE:     value_mode     <= mode_t'(wr_data[1:0]);
        REG_SCALE_FACTOR:   scale_factor   <= $signed(wr_data[31:0]);
        REG_SCALE_OFFSET:   scale_offset   <= $signed(wr_data);
        REG_CLAMP_LOW:      clamp_low      <= $signed(wr_data);
        REG_CLAMP_HIGH:     clamp_high     <= $signed(wr_data);
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    ext_cfg.start_position = start_position;
    ext_cfg.bit_count      = bit_count;
    ext_cfg.big_endian     = big_endian;
    ext_cfg.value_mode     = value_mode;
    scl_cfg.scale_factor   = scale_factor;
    scl_cfg.scale_offset   = scale_offset;
    scl_cfg.clamp_low      = clamp_low;
    scl_cfg.clamp_high     = clamp_high;
  end

  cses_front u_front (
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .frame       (frame),
    .cfg         (ext_cfg),
    .queue_full  (full),
    .push        (push),
    .entry       (wr_entry)
  );

  cses_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_entry  (wr_entry),
    .pop       (pop),
    .rd_entry  (rd_entry),
    .not_empty (not_empty),
    .full      (full)
  );

  cses_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (scl_cfg),
    .entry_valid  (not_empty),
    .entry        (rd_entry),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.ok |-> result.raw_value == 64'sd0 &&
                                   result.scaled_value == 64'sd0)
    else $error("failed transaction carries nonzero values");

  a_disabled_fails: assert property (@(posedge clk) disable iff (rst)
    result_valid && value_mode == MODE_DISABLED |-> !result.ok)
    else $error("disabled signal reported ok");

  a_string_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && value_mode == MODE_STRING |->
      result.ok && result.raw_value == 64'sd0 && result.scaled_value == 64'sd0)
    else $error("string mode transaction not ok with zero values");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

endmodule
`default_nettype wire

[src/cses_front.sv]
// Front end: accepts frames, classifies them and extracts the raw signal bits.
`default_nettype none
module cses_front (
  input  wire logic                  frame_valid,
  output logic                       frame_stall,
  input  wire cses_pkg::frame_t      frame,
  input  wire cses_pkg::extract_cfg_t cfg,
  input  wire logic                  queue_full,
  output logic                       push,
  output cses_pkg::entry_t           entry
);
  import cses_pkg::*;

  logic [3:0]  nbytes;
  logic [7:0]  end_sum;
  logic        fits;
  logic [63:0] mask;
  logic [63:0] swapped;
  logic [7:0]  moto_shift;
  logic [63:0] bits;
  logic [63:0] raw;
  logic [5:0]  sign_pos;

  assign frame_stall = queue_full;
  assign push        = frame_valid && !queue_full;

  always_comb begin
    nbytes = (frame.payload_bytes > 4'(MAX_PAYLOAD_BYTES)) ? 4'(MAX_PAYLOAD_BYTES)
                                                           : frame.payload_bytes;
    end_sum = 8'(cfg.start_position) + 8'(cfg.bit_count) + 8'd7;
    fits    = (end_sum[7:3] <= 5'(nbytes)) && (cfg.bit_count <= 7'd64);

    mask = ~((~64'd0) << cfg.bit_count);
    for (int k = 0; k < 8; k++) begin
      swapped[k*8 +: 8] = frame.payload[(7-k)*8 +: 8];
    end
    // Motorola: byte-swapped word, MSB of signal at bit 63-start
    moto_shift = 8'd64 - 8'(cfg.start_position) - 8'(cfg.bit_count);
    if (cfg.big_endian) begin
      bits = swapped >> moto_shift[6:0];
    end else begin
      bits = frame.payload >> cfg.start_position;
    end
    raw = bits & mask;

    sign_pos = 6'(cfg.bit_count - 7'd1);
    if (cfg.value_mode == MODE_SIGNED && cfg.bit_count != 7'd0 &&
        cfg.bit_count < 7'd64 && raw[sign_pos]) begin
      raw = raw | ~mask;
    end

    entry.ok       = 1'b0;
    entry.scale_en = 1'b0;
    entry.raw      = '0;
    case (cfg.value_mode)
      MODE_DISABLED: begin
      end
      MODE_STRING: begin
        entry.ok = 1'b1;
      end
      default: begin
        if (fits) begin
          entry.ok       = 1'b1;
          entry.scale_en = 1'b1;
          entry.raw      = raw;
        end
      end
    endcase
  end

endmodule
`default_nettype wire

[src/cses_queue.sv]
// Short queue between the extract front end and the scaling back end.
`default_nettype none
module cses_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire cses_pkg::entry_t wr_entry,
  input  wire logic             pop,
  output cses_pkg::entry_t      rd_entry,
  output logic                  not_empty,
  output logic                  full
);
  import cses_pkg::*;

  entry_t                   slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]   wr_ptr;
  logic [QUEUE_PTR_W-1:0]   rd_ptr;
  logic [QUEUE_PTR_W:0]     count;

  assign not_empty = (count != '0);
  assign full      = (count == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign rd_entry  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

[src/cses_back.sv]
// Back end: multiply by factor, add offset, saturate and clamp, result register.
`default_nettype none
module cses_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cses_pkg::scale_cfg_t cfg,
  input  wire logic                entry_valid,
  input  wire cses_pkg::entry_t    entry,
  output logic                     pop,
  output logic                     result_valid,
  input  wire logic                result_stall,
  output cses_pkg::result_t        result
);
  import cses_pkg::*;

  localparam logic signed [63:0] SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SAT_MIN = 64'sh8000_0000_0000_0000;

  logic advance;

  // stage 1: partial products
  logic               s1_valid;
  logic               s1_ok;
  logic               s1_scale_en;
  logic signed [63:0] s1_raw;
  logic signed [64:0] s1_pp_lo;
  logic signed [63:0] s1_pp_hi;

  // stage 2: sum and saturate
  logic               s2_valid;
  logic               s2_ok;
  logic               s2_scale_en;
  logic signed [63:0] s2_raw;
  logic signed [63:0] s2_sat;

  logic signed [64:0] pp_lo_next;
  logic signed [63:0] pp_hi_next;
  logic signed [96:0] sum;
  logic signed [63:0] sat_next;
  logic signed [63:0] lo_bound;
  logic signed [63:0] hi_bound;
  logic signed [63:0] clamped;

  assign advance = !(result_valid && result_stall);
  assign pop     = advance && entry_valid;

  always_comb begin
    pp_lo_next = $signed({1'b0, entry.raw[31:0]}) * cfg.scale_factor;
    pp_hi_next = $signed(entry.raw[63:32]) * cfg.scale_factor;
  end

  always_comb begin
    sum = (97'(s1_pp_hi) <<< 32) + 97'(s1_pp_lo) + 97'(cfg.scale_offset);
    if ((&sum[96:63]) || !(|sum[96:63])) begin
      sat_next = sum[63:0];
    end else if (sum[96]) begin
      sat_next = SAT_MIN;
    end else begin
      sat_next = SAT_MAX;
    end
  end

  always_comb begin
    lo_bound = 64'(cfg.clamp_low);
    hi_bound = 64'(cfg.clamp_high);
    clamped  = s2_sat;
    if (!(lo_bound == 64'sd0 && hi_bound == 64'sd0)) begin
      if (s2_sat < lo_bound) begin
        clamped = lo_bound;
      end else if (hi_bound < s2_sat) begin
        clamped = hi_bound;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_ok        <= entry.ok;
      s1_scale_en  <= entry.scale_en;
      s1_raw       <= entry.raw;
      s1_pp_lo     <= pp_lo_next;
      s1_pp_hi     <= pp_hi_next;
      s2_ok        <= s1_ok;
      s2_scale_en  <= s1_scale_en;
      s2_raw       <= s1_raw;
      s2_sat       <= sat_next;
      result.ok           <= s2_ok;
      result.raw_value    <= s2_raw;
      result.scaled_value <= s2_scale_en ? clamped : 64'sd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else if (advance) begin
      s1_valid     <= entry_valid;
      s2_valid     <= s1_valid;
      result_valid <= s2_valid;
    end
  end

endmodule
`default_nettype wire
